/* design/box_blur_3x3_edge_aware_assert.svh */
// Assertion macros for the box blur block.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_ASSERT_SVH

// Condition holds at every edge out of reset.
`define BB3_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define BB3_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bb3_pkg.sv */
// Shared types, constants and helpers for the box blur block.
package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int OROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int CNT_W  = 4;
    localparam int SUM_W  = CH_W + 4;
    localparam int NUM_W  = SUM_W + 1;
    localparam int RCP_SHIFT = 18;
    localparam int RCP_W  = 18;
    localparam int PROD_W = NUM_W + RCP_W;

    // ceil(2^RCP_SHIFT / (2*count)), exact floor for every numerator in range
    localparam int RCP_1 = (2**RCP_SHIFT + 1) / 2;
    localparam int RCP_2 = (2**RCP_SHIFT + 3) / 4;
    localparam int RCP_3 = (2**RCP_SHIFT + 5) / 6;
    localparam int RCP_4 = (2**RCP_SHIFT + 7) / 8;
    localparam int RCP_6 = (2**RCP_SHIFT + 11) / 12;
    localparam int RCP_9 = (2**RCP_SHIFT + 17) / 18;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } bb3_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            frame_end;
    } bb3_out_t;

    typedef logic [2:0][2:0][PIX_W-1:0] bb3_taps_t;
    typedef logic [2:0][2:0][CH_W-1:0]  bb3_chan_t;

    typedef struct packed {
        logic             shift;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] px;
        logic [2:0]       row_ok;
        logic [2:0]       col_ok;
    } bb3_win_ctrl_t;

    typedef struct packed {
        logic             sum_en;
        logic             mul_en;
        logic [CNT_W-1:0] count;
    } bb3_lane_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SUM,
        ST_MUL,
        ST_PUSH
    } bb3_state_t;

    function automatic logic [RCP_W-1:0] bb3_recip(input logic [CNT_W-1:0] cnt);
        logic [RCP_W-1:0] r;
        case (cnt)
            CNT_W'(1): r = RCP_W'(RCP_1);
            CNT_W'(2): r = RCP_W'(RCP_2);
            CNT_W'(3): r = RCP_W'(RCP_3);
            CNT_W'(4): r = RCP_W'(RCP_4);
            CNT_W'(6): r = RCP_W'(RCP_6);
            CNT_W'(9): r = RCP_W'(RCP_9);
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

/* design/bb3_ram.sv */
// Generic single-write, registered-read RAM.
module bb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/bb3_window.sv */
// Line stores, 3x3 window and masked tap capture.
module bb3_window import bb3_pkg::*; (
    input  logic          clk,
    input  bb3_win_ctrl_t ctrl,
    output bb3_taps_t     taps
);

    logic [PIX_W-1:0] upper_rd;
    logic [PIX_W-1:0] middle_rd;
    bb3_taps_t        win_reg;
    bb3_taps_t        win_next;
    bb3_taps_t        taps_reg;
    bb3_taps_t        taps_next;
    logic [2:0][PIX_W-1:0] new_col;

    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (ctrl.shift),
        .waddr (ctrl.col),
        .wdata (middle_rd),
        .raddr (ctrl.col),
        .rdata (upper_rd)
    );

    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (ctrl.shift),
        .waddr (ctrl.col),
        .wdata (ctrl.px),
        .raddr (ctrl.col),
        .rdata (middle_rd)
    );

    // view columns: old col 1 = left, old col 2 = center, incoming = right
    always_comb
    begin
        new_col[0] = upper_rd;
        new_col[1] = middle_rd;
        new_col[2] = ctrl.px;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
            win_next[r][2] = new_col[r];
            for (int c = 0; c < 3; c++)
            begin
                taps_next[r][c] = (ctrl.row_ok[r] && ctrl.col_ok[c]) ? win_next[r][c] : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            win_reg  <= win_next;
            taps_reg <= taps_next;
        end
    end

    assign taps = taps_reg;

endmodule

/* design/bb3_lane.sv */
// One color lane: neighborhood sum and rounded mean by reciprocal multiply.
module bb3_lane import bb3_pkg::*; (
    input  logic            clk,
    input  bb3_lane_ctrl_t  ctrl,
    input  bb3_chan_t       vals,
    output logic [CH_W-1:0] mean
);

    logic [SUM_W-1:0]  row_sum [3];
    logic [SUM_W-1:0]  total;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  num_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = SUM_W'(vals[r][0]) + SUM_W'(vals[r][1]) + SUM_W'(vals[r][2]);
        end
        total     = row_sum[0] + row_sum[1] + row_sum[2];
        num_next  = {total, 1'b0} + NUM_W'(ctrl.count);
        prod_next = PROD_W'(num_reg) * PROD_W'(bb3_recip(ctrl.count));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            num_reg <= num_next;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign mean = prod_reg[RCP_SHIFT +: CH_W];

endmodule

/* design/box_blur_3x3_edge_aware.sv */
// Top level: 3x3 edge-aware box blur of raster RGB pixels.
// A beat that gives no result passes through accept, then line store update;
// a drain beat that arrives mid-frame is dropped in its accept cycle. A beat that
// gives a result passes through accept, window shift and line store update,
// neighborhood sum, reciprocal multiply, and load of the output register, which
// waits while the output register stays stalled. The steps follow from the registered
// read of the line stores and the single-item sequencer that drives the three
// color lanes. The output register holds a finished result while the next beat
// is accepted. Results lag the input by one row plus one pixel; after a frame,
// frame_width+1 drain beats flush it. A configuration write abandons the frame.
`include "box_blur_3x3_edge_aware_assert.svh"
module box_blur_3x3_edge_aware import bb3_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  bb3_in_t               pixel,
    output logic                  result_valid,
    input  logic                  result_stall,
    output bb3_out_t              result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    bb3_state_t        state_reg, state_next;
    logic [FW_W-1:0]   frame_width_reg, frame_width_next;
    logic [FH_W-1:0]   frame_height_reg, frame_height_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [IROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;
    logic [PIX_W-1:0]  px_reg, px_next;
    logic              emit_reg, emit_next;
    logic              fe_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              out_valid_reg, out_valid_next;
    bb3_out_t          out_reg;

    logic [WID_W-1:0]  eff_w;
    logic [HGT_W-1:0]  eff_h;
    logic              accept;
    logic              draining;
    logic              cfg_write;
    logic              load_out;
    logic              fe_now;
    logic [2:0]        row_ok;
    logic [2:0]        col_ok;
    logic [1:0]        rows_in;
    logic [1:0]        cols_in;
    logic [CNT_W-1:0]  count_now;

    bb3_win_ctrl_t     win_ctrl;
    bb3_lane_ctrl_t    lane_ctrl;
    bb3_taps_t         taps;
    bb3_chan_t         chan_taps [3];
    logic [CH_W-1:0]   mean [3];

    always_comb
    begin
        if (frame_width_reg == '0)
            eff_w = WID_W'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            eff_w = WID_W'(MAX_WIDTH);
        else
            eff_w = WID_W'(frame_width_reg);

        if (frame_height_reg == '0)
            eff_h = HGT_W'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            eff_h = HGT_W'(MAX_HEIGHT);
        else
            eff_h = HGT_W'(frame_height_reg);
    end

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign pixel_stall = (state_reg != ST_IDLE);
    assign accept      = pixel_valid && !pixel_stall;
    assign draining    = 32'(in_row_reg) >= 32'(eff_h);
    assign load_out    = (state_reg == ST_PUSH) && (!out_valid_reg || !result_stall);

    // neighborhood mask around the output position
    always_comb
    begin
        row_ok[0] = (out_row_reg != '0);
        row_ok[1] = 1'b1;
        row_ok[2] = (32'(out_row_reg) + 1) < 32'(eff_h);
        col_ok[0] = (out_col_reg != '0);
        col_ok[1] = 1'b1;
        col_ok[2] = (32'(out_col_reg) + 1) < 32'(eff_w);
        rows_in   = 2'(row_ok[0]) + 2'(row_ok[1]) + 2'(row_ok[2]);
        cols_in   = 2'(col_ok[0]) + 2'(col_ok[1]) + 2'(col_ok[2]);
        count_now = CNT_W'(rows_in) * CNT_W'(cols_in);
        fe_now    = (32'(out_row_reg) == 32'(eff_h) - 1) && (32'(out_col_reg) == 32'(eff_w) - 1);
    end

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        emit_next  = emit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !(pixel.kind == KIND_DRAIN && !draining))
                begin
                    state_next = ST_SHIFT;
                    px_next    = draining ? '0
                               : {pixel.red_in, pixel.green_in, pixel.blue_in};
                    emit_next  = (32'(in_row_reg) >= 2)
                               || (in_row_reg == IROW_W'(1) && in_col_reg != '0);
                end
            end
            ST_SHIFT: state_next = emit_reg ? ST_SUM : ST_IDLE;
            ST_SUM:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_PUSH;
            ST_PUSH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        in_col_next       = in_col_reg;
        in_row_next       = in_row_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;

        if (state_reg == ST_SHIFT)
        begin
            if ((32'(in_col_reg) + 1) >= 32'(eff_w))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit_reg)
            begin
                if (fe_now)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if ((32'(out_col_reg) + 1) >= 32'(eff_w))
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end

        if (cfg_write && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT))
        begin
            if (cfg_index == REG_FRAME_WIDTH)
                frame_width_next = cfg_data[FW_W-1:0];
            else
                frame_height_next = cfg_data[FH_W-1:0];
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (result_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frame_width_reg  <= FW_W'(640);
            frame_height_reg <= FH_W'(480);
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            emit_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
            emit_reg         <= emit_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        if (state_reg == ST_SHIFT)
        begin
            fe_reg    <= fe_now;
            count_reg <= count_now;
        end
        if (load_out)
        begin
            out_reg.red_out   <= mean[0];
            out_reg.green_out <= mean[1];
            out_reg.blue_out  <= mean[2];
            out_reg.frame_end <= fe_reg;
        end
    end

    assign win_ctrl.shift  = (state_reg == ST_SHIFT);
    assign win_ctrl.col    = in_col_reg;
    assign win_ctrl.px     = px_reg;
    assign win_ctrl.row_ok = row_ok;
    assign win_ctrl.col_ok = col_ok;

    bb3_window u_window (
        .clk  (clk),
        .ctrl (win_ctrl),
        .taps (taps)
    );

    assign lane_ctrl.sum_en = (state_reg == ST_SUM);
    assign lane_ctrl.mul_en = (state_reg == ST_MUL);
    assign lane_ctrl.count  = count_reg;

    // lane 0 red, 1 green, 2 blue
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    chan_taps[l][r][c] = taps[r][c][PIX_W-1-CH_W*l -: CH_W];
                end
            end
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        bb3_lane u_lane (
            .clk  (clk),
            .ctrl (lane_ctrl),
            .vals (chan_taps[g]),
            .mean (mean[g])
        );
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `BB3_ASSERT_ALWAYS(a_out_col_in_frame, 32'(out_col_reg) < 32'(eff_w), "output column past frame")
    `BB3_ASSERT_IMPLY(a_count_nonzero, state_reg == ST_SUM, count_reg != '0, "empty neighborhood")
    `BB3_ASSERT_NEXT(a_push_waits, (state_reg == ST_PUSH) && out_valid_reg && result_stall, state_reg == ST_PUSH, "result overwritten while stalled")
    `BB3_ASSERT_IMPLY(a_frame_end_clears, (state_reg == ST_PUSH) && fe_reg, (out_row_reg == '0) && (out_col_reg == '0) && (in_row_reg == '0), "positions not cleared at frame end")

endmodule

/* tb/box_blur_3x3_edge_aware_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 edge-aware box blur: predicts every output beat.
module box_blur_3x3_edge_aware_tb;
    import bb3_pkg::*;

    localparam int RANDOM_ITEMS   = 420;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int RESET_RUN      = 20;
    localparam int MAX_REPORTS    = 10;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  pixel_valid;
    logic                  pixel_stall;
    bb3_in_t               pixel;
    logic                  result_valid;
    logic                  result_stall;
    bb3_out_t              result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit          steady_flow;
    int unsigned hold_off_cycles;
    int unsigned mismatch_count;

    // blur predictor state
    logic [FW_W-1:0]   width_reg;
    logic [FH_W-1:0]   height_reg;
    logic [PIX_W-1:0]  upper_row [MAX_WIDTH];
    logic [PIX_W-1:0]  middle_row [MAX_WIDTH];
    logic [PIX_W-1:0]  taps [3][3];
    logic [WID_W-1:0]  in_col;
    logic [IROW_W-1:0] in_row;
    logic [WID_W-1:0]  out_col;
    logic [OROW_W-1:0] out_row;
    bb3_out_t          expected_blur_q[$];

    box_blur_3x3_edge_aware DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int unsigned span_width();
        if (width_reg == '0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned span_height();
        if (height_reg == '0)
            return 1;
        if (height_reg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic void restart_frame();
        in_col  = '0;
        in_row  = '0;
        out_col = '0;
        out_row = '0;
    endfunction

    function automatic void shift_taps(input logic [PIX_W-1:0] px);
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        int r;
        top = upper_row[in_col];
        mid = middle_row[in_col];
        upper_row[in_col]  = mid;
        middle_row[in_col] = px;
        for (r = 0; r < 3; r++)
        begin
            taps[r][0] = taps[r][1];
            taps[r][1] = taps[r][2];
        end
        taps[0][2] = top;
        taps[1][2] = mid;
        taps[2][2] = px;
    endfunction

    // centre: window column that holds the output pixel's column
    function automatic bb3_out_t blur_window(input int centre, input int w, input int h);
        int sum_r;
        int sum_g;
        int sum_b;
        int count;
        int dy;
        int dx;
        int yy;
        int xx;
        int wc;
        logic [PIX_W-1:0] px;
        bb3_out_t res;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        count = 0;
        for (dy = -1; dy <= 1; dy++)
        begin
            yy = int'(out_row) + dy;
            if (yy >= 0 && yy < h)
            begin
                for (dx = -1; dx <= 1; dx++)
                begin
                    xx = int'(out_col) + dx;
                    wc = centre + dx;
                    if (xx >= 0 && xx < w && wc >= 0 && wc <= 2)
                    begin
                        px = taps[dy + 1][wc];
                        sum_r += px[23:16];
                        sum_g += px[15:8];
                        sum_b += px[7:0];
                        count++;
                    end
                end
            end
        end
        res.red_out   = CH_W'((2 * sum_r + count) / (2 * count));
        res.green_out = CH_W'((2 * sum_g + count) / (2 * count));
        res.blue_out  = CH_W'((2 * sum_b + count) / (2 * count));
        res.frame_end = (int'(out_row) == h - 1) && (int'(out_col) == w - 1);
        return res;
    endfunction

    task automatic blur_predict_beat(input bb3_in_t beat);
        int w;
        int h;
        logic [PIX_W-1:0] px;
        bit draining;
        bit emit;
        bb3_out_t res;
        w = span_width();
        h = span_height();
        draining = (in_row >= h);
        if (beat.kind == KIND_DRAIN && !draining)
            return;
        px = draining ? '0 : {beat.red_in, beat.green_in, beat.blue_in};
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (emit && in_col == 0)
            res = blur_window(2, w, h);
        shift_taps(px);
        if (emit && in_col != 0)
            res = blur_window(1, w, h);
        in_col++;
        if (in_col >= w)
        begin
            in_col = '0;
            in_row++;
        end
        if (emit)
        begin
            expected_blur_q.push_back(res);
            if (res.frame_end)
                restart_frame();
            else
            begin
                out_col++;
                if (out_col >= w)
                begin
                    out_col = '0;
                    out_row++;
                end
            end
        end
    endtask

    function automatic int unsigned idle_len();
        int unsigned roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] rand_rgb();
        logic [PIX_W-1:0] rgb;
        int c;
        rgb = PIX_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            for (c = 0; c < 3; c++)
                rgb[c * CH_W +: CH_W] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return rgb;
    endfunction

    function automatic bb3_in_t pixel_beat(input logic kind, input logic [PIX_W-1:0] rgb);
        bb3_in_t b;
        b.kind     = kind;
        b.red_in   = rgb[23:16];
        b.green_in = rgb[15:8];
        b.blue_in  = rgb[7:0];
        return b;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size(input int unsigned common_max,
                                                       input int unsigned rare_max);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return '0;
        if (roll < 90)
            return CFG_DATA_W'($urandom_range(1, common_max));
        return CFG_DATA_W'($urandom_range(common_max + 1, rare_max));
    endfunction

    task automatic flag_mismatch(input string note);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s", $time, note);
    endtask

    task automatic send_beat(input bb3_in_t beat);
        int unsigned gap;
        gap = idle_len();
        @(negedge clk);
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel       <= beat;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (pixel_stall !== 1'b0)
            @(posedge clk);
        blur_predict_beat(beat);
    endtask

    task automatic settle();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (expected_blur_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        if (idx == REG_FRAME_WIDTH)
            width_reg = val[FW_W-1:0];
        else if (idx == REG_FRAME_HEIGHT)
            height_reg = val[FH_W-1:0];
        restart_frame();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic setup_frame(input logic [CFG_DATA_W-1:0] width_val,
                               input logic [CFG_DATA_W-1:0] height_val);
        settle();
        write_reg(REG_FRAME_WIDTH, width_val);
        write_reg(REG_FRAME_HEIGHT, height_val);
    endtask

    // broken: stray drains, data beats in the drain phase, extra drains, early cut
    task automatic send_frame(input bit broken);
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned cut;
        w = span_width();
        h = span_height();
        cut = 0;
        if (broken && w * h > 1 && $urandom_range(0, 2) == 0)
            cut = $urandom_range(1, w * h - 1);
        for (n = 0; n < w * h; n++)
        begin
            if (broken && $urandom_range(0, 7) == 0)
                send_beat(pixel_beat(KIND_DRAIN, rand_rgb()));
            if (cut != 0 && n == cut)
                return;
            send_beat(pixel_beat(KIND_PIXEL, rand_rgb()));
        end
        for (n = 0; n <= w; n++)
            send_beat(pixel_beat((broken && $urandom_range(0, 3) == 0) ? KIND_PIXEL : KIND_DRAIN,
                                 rand_rgb()));
        if (broken)
            repeat ($urandom_range(1, 3)) send_beat(pixel_beat(KIND_DRAIN, rand_rgb()));
    endtask

    // reset geometry: a short run inside the first row gives no output
    task automatic test_default_geometry();
        int n;
        for (n = 0; n < RESET_RUN; n++)
            send_beat(pixel_beat(KIND_PIXEL, rand_rgb()));
    endtask

    task automatic test_directed_edges();
        logic [PIX_W-1:0] frame_px [9];
        int n;
        frame_px = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                     24'h000000, 24'hFFFFFF, 24'h000000,
                     24'h01FF80, 24'hFE0001, 24'h7F807F};
        setup_frame(3, 3);
        for (n = 0; n < 9; n++)
        begin
            if (n == 4)
                send_beat(pixel_beat(KIND_DRAIN, 24'hABCDEF));
            send_beat(pixel_beat(KIND_PIXEL, frame_px[n]));
        end
        // data beat after the last pixel acts as a drain
        send_beat(pixel_beat(KIND_PIXEL, 24'h123456));
        for (n = 0; n < 3; n++)
            send_beat(pixel_beat(KIND_DRAIN, 24'h000000));
        send_beat(pixel_beat(KIND_DRAIN, 24'hFFFFFF));
        // zero sizes clamp to a single-pixel frame
        setup_frame(0, 0);
        send_beat(pixel_beat(KIND_PIXEL, 24'hA5C3E1));
        send_beat(pixel_beat(KIND_DRAIN, 24'h000000));
        send_beat(pixel_beat(KIND_DRAIN, 24'h000000));
        send_beat(pixel_beat(KIND_DRAIN, 24'h5A5A5A));
    endtask

    task automatic test_register_extremes();
        // bits above the width field are dropped
        setup_frame(13'h0803, 2);
        send_frame(1'b0);
        setup_frame(1, 5);
        send_frame(1'b0);
        setup_frame(7, 1);
        send_frame(1'b0);
    endtask

    task automatic test_output_backpressure();
        setup_frame(8, 6);
        steady_flow = 1'b1;
        hold_off_cycles = HOLD_OFF_LEN;
        send_frame(1'b0);
        steady_flow = 1'b0;
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        bit broken;
        bit resize;
        sent = 0;
        resize = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            steady_flow = ($urandom_range(0, 5) == 0);
            if (resize || $urandom_range(0, 3) != 0)
                setup_frame(pick_size(10, 20), pick_size(6, 10));
            broken = ($urandom_range(0, 4) == 0);
            send_frame(broken);
            sent += span_width() * span_height() + span_width() + 1;
            resize = broken;
        end
        steady_flow = 1'b0;
    endtask

    always @(posedge clk)
    begin
        bb3_out_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (expected_blur_q.size() == 0)
                flag_mismatch($sformatf("unexpected beat rgb %h %h %h end %b",
                    result.red_out, result.green_out, result.blue_out, result.frame_end));
            else
            begin
                want = expected_blur_q.pop_front();
                if (result.red_out !== want.red_out || result.green_out !== want.green_out
                    || result.blue_out !== want.blue_out
                    || result.frame_end !== want.frame_end)
                    flag_mismatch($sformatf(
                        "rgb %h %h %h end %b, expected rgb %h %h %h end %b",
                        result.red_out, result.green_out, result.blue_out, result.frame_end,
                        want.red_out, want.green_out, want.blue_out, want.frame_end));
            end
        end
    end

    initial
    begin
        int unsigned stall_run;
        stall_run = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles != 0)
            begin
                result_stall <= 1'b1;
                hold_off_cycles--;
            end
            else if (stall_run != 0)
            begin
                result_stall <= 1'b1;
                stall_run--;
            end
            else
            begin
                stall_run = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
                result_stall <= (stall_run != 0);
                if (stall_run != 0)
                    stall_run--;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        pixel_valid <= 1'b0;
        pixel       <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        width_reg  = FW_W'(RESET_WIDTH);
        height_reg = FH_W'(RESET_HEIGHT);
        foreach (upper_row[i])
        begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        foreach (taps[r, c])
            taps[r][c] = '0;
        restart_frame();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_geometry();
        test_directed_edges();
        test_register_extremes();
        test_output_backpressure();
        test_random_frames();
        settle();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* box_blur_3x3_edge_aware.f */
+incdir+design
design/bb3_pkg.sv
design/bb3_ram.sv
design/bb3_window.sv
design/bb3_lane.sv
design/box_blur_3x3_edge_aware.sv
tb/box_blur_3x3_edge_aware_tb.sv
